// ===== rtl/sbq_pkg.sv =====
package sbq_pkg;

  // Number of entries in each of the transmit and receive rings.
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned ByteW      = 8;

  typedef enum logic [1:0] {
    OpQueueTx = 2'd0,
    OpTakeRx  = 2'd1,
    OpDone    = 2'd2,
    OpClear   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StTxFull  = 2'd1,
    StRxEmpty = 2'd2
  } status_e;

  // Requests from the top level to one ring.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_ctrl_t;

  // Fill state of one ring.
  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

// ===== rtl/spi_buffered_byte_queues_top.sv =====
// Transmit and receive byte rings in front of an SPI byte shifter.
// The input channel (in_valid_i / in_stall_o) carries one request item: op_i selects
// queue a byte to send, take a received byte, report a finished transfer (data_in_i
// holds the byte shifted in) or clear both rings. Every accepted item yields exactly
// one result item on the output channel (out_valid_o / out_stall_i): a status code,
// the byte taken from the receive ring, a start strobe with the byte to hand to the
// shifter, and an overflow flag when a received byte had to be dropped.
// The result of an accepted item is registered and presented in the cycle after
// it is accepted. Throughput is one item per cycle while the receiver does not
// stall; the ring RAMs are read with a registered port, so the popped byte lands
// directly in the result stage. When the receiver stalls, the result stays put and
// in_stall_o rises, so at most one result waits; a new item is taken in the same
// cycle that the waiting result is taken.
// Reset empties both rings, marks the shifter idle and drops any pending result.
// The ring storage itself is not cleared; only written entries are ever read.
module spi_buffered_byte_queues_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                op_i,
  input  logic [sbq_pkg::ByteW-1:0] data_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [sbq_pkg::ByteW-1:0] data_out_o,
  output logic                      start_send_o,
  output logic [sbq_pkg::ByteW-1:0] send_byte_o,
  output logic                      rx_overflow_o
);

  sbq_pkg::op_e        op;
  logic                accept;
  sbq_pkg::ring_ctrl_t tx_ctrl, rx_ctrl;
  sbq_pkg::ring_stat_t tx_stat, rx_stat;
  logic [sbq_pkg::ByteW-1:0] tx_rdata, rx_rdata;
  sbq_pkg::status_e    status_d;

  logic busy_q, busy_d;
  logic out_valid_q;

  // Result stage payload.
  sbq_pkg::status_e          status_q;
  logic                      take_q;
  logic                      start_q;
  logic                      bypass_q;
  logic [sbq_pkg::ByteW-1:0] byte_q;
  logic                      ovf_q;

  assign op         = sbq_pkg::op_e'(op_i);
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    tx_ctrl  = '0;
    rx_ctrl  = '0;
    status_d = sbq_pkg::StOk;
    busy_d   = busy_q;
    if (accept) begin
      case (op)
        sbq_pkg::OpQueueTx: begin
          if (tx_stat.full) begin
            status_d = sbq_pkg::StTxFull;
          end else begin
            tx_ctrl.push = 1'b1;
            // An idle shifter takes the oldest byte at once.
            tx_ctrl.pop  = !busy_q;
          end
        end
        sbq_pkg::OpTakeRx: begin
          if (rx_stat.empty) begin
            status_d = sbq_pkg::StRxEmpty;
          end else begin
            rx_ctrl.pop = 1'b1;
          end
        end
        sbq_pkg::OpDone: begin
          tx_ctrl.pop  = !tx_stat.empty;
          rx_ctrl.push = !rx_stat.full;
          if (tx_stat.empty) begin
            busy_d = 1'b0;
          end
        end
        sbq_pkg::OpClear: begin
          // The byte in flight still finishes, so the busy flag is kept.
          tx_ctrl.clear = 1'b1;
          rx_ctrl.clear = 1'b1;
        end
        default: begin
          status_d = sbq_pkg::StOk;
        end
      endcase
      if (tx_ctrl.pop) begin
        busy_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      take_q   <= rx_ctrl.pop;
      start_q  <= tx_ctrl.pop;
      // With an empty ring the byte being queued is the one that starts.
      bypass_q <= tx_stat.empty;
      byte_q   <= data_in_i;
      ovf_q    <= (op == sbq_pkg::OpDone) && rx_stat.full;
    end
  end

  sbq_ring u_tx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tx_ctrl),
    .wdata_i (data_in_i),
    .stat_o  (tx_stat),
    .rdata_o (tx_rdata)
  );

  sbq_ring u_rx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rx_ctrl),
    .wdata_i (data_in_i),
    .stat_o  (rx_stat),
    .rdata_o (rx_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign data_out_o    = take_q ? rx_rdata : '0;
  assign start_send_o  = start_q;
  assign send_byte_o   = start_q ? (bypass_q ? byte_q : tx_rdata) : '0;
  assign rx_overflow_o = ovf_q;

endmodule

// ===== rtl/sbq_ram.sv =====
module sbq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sbq_ring.sv =====
module sbq_ring (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sbq_pkg::ring_ctrl_t      ctrl_i,
  input  logic [sbq_pkg::ByteW-1:0] wdata_i,
  output sbq_pkg::ring_stat_t      stat_o,
  output logic [sbq_pkg::ByteW-1:0] rdata_o
);

  localparam logic [sbq_pkg::PtrW-1:0] LastPtr = sbq_pkg::PtrW'(sbq_pkg::QueueDepth - 1);
  localparam logic [sbq_pkg::CntW-1:0] FullCnt = sbq_pkg::CntW'(sbq_pkg::QueueDepth);

  logic [sbq_pkg::PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [sbq_pkg::PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [sbq_pkg::CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (ctrl_i.clear) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      count_d  = '0;
    end else begin
      if (ctrl_i.push) begin
        wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (ctrl_i.pop) begin
        rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (ctrl_i.push && !ctrl_i.pop) begin
        count_d = count_q + 1'b1;
      end else if (ctrl_i.pop && !ctrl_i.push) begin
        count_d = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == FullCnt);

  // The popped entry appears on rdata_o in the cycle after the pop.
  sbq_ram #(
    .Width(sbq_pkg::ByteW),
    .Depth(sbq_pkg::QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push && !ctrl_i.clear),
    .waddr_i (wr_ptr_q),
    .wdata_i (wdata_i),
    .re_i    (ctrl_i.pop && !ctrl_i.clear),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata_o)
  );

endmodule

// ===== bench/spi_buffered_byte_queues_top_test.sv =====
module spi_buffered_byte_queues_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod  = 8;
  localparam int ResetCycles = 6;
  localparam int ItemTarget = 520;     // directed items plus about 500 random ones
  localparam int HoldCycles = 100;     // long receiver hold-off that fills the block
  localparam int CycleLimit = 200000;  // far above the slowest legal run
  localparam int TailCycles = 8;       // results are registered, so this short tail is plenty

  // One request item as the driver presents it.
  typedef struct packed {
    sbq_pkg::op_e op;
    logic [7:0]   data;
  } request_t;

  // One result item, field for field as the block presents it.
  typedef struct {
    sbq_pkg::status_e status;
    logic [7:0]       data_out;
    logic             start_send;
    logic [7:0]       send_byte;
    logic             rx_overflow;
  } reply_t;

  // Clock, reset and block ports. Every input starts at a known value.
  logic         clk_i       = 1'b0;
  logic         rst_ni      = 1'b0;
  logic         in_valid_i  = 1'b0;
  logic         in_stall_o;
  sbq_pkg::op_e op_i        = sbq_pkg::OpQueueTx;
  logic [7:0]   data_in_i   = 8'h00;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic [1:0]   status_o;
  logic [7:0]   data_out_o;
  logic         start_send_o;
  logic [7:0]   send_byte_o;
  logic         rx_overflow_o;

  spi_buffered_byte_queues_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .data_in_i    (data_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .start_send_o (start_send_o),
    .send_byte_o  (send_byte_o),
    .rx_overflow_o(rx_overflow_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Stimulus waiting to be offered, and the results that accepted requests must produce.
  request_t requests_to_send[$];
  reply_t   awaited_replies[$];

  // Our own copy of the queue state. SystemVerilog queues stand in for the rings and
  // their pointers: only order and fill level are visible from outside.
  logic [7:0] tx_backlog[$];
  logic [7:0] rx_backlog[$];
  logic       shifting = 1'b0;

  // Bookkeeping.
  int  total_items        = 0;
  int  items_accepted     = 0;
  int  mismatches         = 0;
  int  cycle_count        = 0;
  int  input_stall_cycles = 0;
  int  op_seen[4]         = '{0, 0, 0, 0};
  int  tx_refusals        = 0;
  int  rx_empty_answers   = 0;
  int  rx_drops           = 0;
  int  shifter_starts     = 0;
  logic steady_flow       = 1'b0;  // when set, neither side idles or stalls at random
  int  holds_wanted       = 0;     // bumped by the sequencer to ask for a long hold-off
  int  holds_done         = 0;

  // Work out the result of one request and advance our copy of the queue state.
  // A transfer-done always serves the transmit side first and then files the received
  // byte; a full receive ring drops that byte but still answers with status ok.
  // A clear empties both rings but leaves the shifter busy flag alone, since the byte
  // already in flight still completes with a later transfer-done.
  function automatic reply_t serve_request(sbq_pkg::op_e op, logic [7:0] din);
    reply_t r;
    r.status      = sbq_pkg::StOk;
    r.data_out    = 8'h00;
    r.start_send  = 1'b0;
    r.send_byte   = 8'h00;
    r.rx_overflow = 1'b0;
    op_seen[op]++;
    case (op)
      sbq_pkg::OpQueueTx: begin
        if (tx_backlog.size() >= sbq_pkg::QueueDepth) begin
          r.status = sbq_pkg::StTxFull;
          tx_refusals++;
        end else begin
          tx_backlog.push_back(din);
          if (!shifting) begin
            r.start_send = 1'b1;
            r.send_byte  = tx_backlog.pop_front();
            shifting     = 1'b1;
          end
        end
      end
      sbq_pkg::OpTakeRx: begin
        if (rx_backlog.size() == 0) begin
          r.status = sbq_pkg::StRxEmpty;
          rx_empty_answers++;
        end else begin
          r.data_out = rx_backlog.pop_front();
        end
      end
      sbq_pkg::OpDone: begin
        if (tx_backlog.size() > 0) begin
          r.start_send = 1'b1;
          r.send_byte  = tx_backlog.pop_front();
          shifting     = 1'b1;
        end else begin
          shifting = 1'b0;
        end
        if (rx_backlog.size() < sbq_pkg::QueueDepth) begin
          rx_backlog.push_back(din);
        end else begin
          r.rx_overflow = 1'b1;
          rx_drops++;
        end
      end
      default: begin
        tx_backlog.delete();
        rx_backlog.delete();
      end
    endcase
    if (r.start_send) shifter_starts++;
    return r;
  endfunction

  // Idle and stall lengths: mostly none, often short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic flag_mismatch(string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic queue_request(sbq_pkg::op_e op, logic [7:0] b);
    request_t req;
    req.op   = op;
    req.data = b;
    requests_to_send.push_back(req);
  endtask

  // Driver. A new item is put up only when the channel is free, that is when nothing
  // is being offered or the item on offer is taken at this edge, so a stalled item
  // never changes. The expected result is computed at the edge that accepts the item.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    request_t nxt;
    int       idle_left;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      idle_left  = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        awaited_replies.push_back(serve_request(op_i, data_in_i));
        items_accepted <= items_accepted + 1;
      end
      if (idle_left > 0) begin
        idle_left--;
        in_valid_i <= 1'b0;
      end else if (requests_to_send.size() > 0) begin
        nxt = requests_to_send.pop_front();
        op_i       <= nxt.op;
        data_in_i  <= nxt.data;
        in_valid_i <= 1'b1;
        idle_left  = steady_flow ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall. A requested hold-off keeps the output stalled for a long stretch
  // while the driver keeps offering items; since the block holds one waiting result
  // at most, its input stall must rise almost at once and stay up.
  always @(posedge clk_i or negedge rst_ni) begin : drive_stall
    int stall_left;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else if (holds_done != holds_wanted) begin
      holds_done  <= holds_done + 1;
      stall_left  = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
      stall_left  = pick_gap();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor. Every taken result is matched against the oldest expectation, field by
  // field; a result that nobody asked for is a failure as well.
  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) input_stall_cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (awaited_replies.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want = awaited_replies.pop_front();
          if (status_o !== want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
          if (data_out_o !== want.data_out)
            flag_mismatch($sformatf("data_out %0h, expected %0h", data_out_o, want.data_out));
          if (start_send_o !== want.start_send)
            flag_mismatch($sformatf("start_send %0b, expected %0b",
                                    start_send_o, want.start_send));
          if (send_byte_o !== want.send_byte)
            flag_mismatch($sformatf("send_byte %0h, expected %0h",
                                    send_byte_o, want.send_byte));
          if (rx_overflow_o !== want.rx_overflow)
            flag_mismatch($sformatf("rx_overflow %0b, expected %0b",
                                    rx_overflow_o, want.rx_overflow));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d of %0d items accepted",
               cycle_count, items_accepted, total_items);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sequencer: builds the stimulus, steers the idle phases and closes the run.
  initial begin : sequencer
    int           burst;
    sbq_pkg::op_e kind;

    // Directed part: both empty answers, transfer-done while idle, the byte extremes,
    // queued bytes leaving in order, clear while idle and clear while busy.
    queue_request(sbq_pkg::OpTakeRx,  8'h00);  // receive ring empty
    queue_request(sbq_pkg::OpDone,    8'h00);  // transfer done while the shifter is idle
    queue_request(sbq_pkg::OpQueueTx, 8'hFF);  // idle shifter takes it at once
    queue_request(sbq_pkg::OpQueueTx, 8'h00);  // shifter busy, byte waits
    queue_request(sbq_pkg::OpQueueTx, 8'h80);
    queue_request(sbq_pkg::OpTakeRx,  8'hFF);
    queue_request(sbq_pkg::OpDone,    8'hFF);  // starts the next waiting byte
    queue_request(sbq_pkg::OpDone,    8'h01);
    queue_request(sbq_pkg::OpDone,    8'h7F);  // nothing left, shifter goes idle
    queue_request(sbq_pkg::OpClear,   8'hFF);  // clear while idle, drops received bytes
    queue_request(sbq_pkg::OpTakeRx,  8'h00);
    queue_request(sbq_pkg::OpQueueTx, 8'h5A);
    queue_request(sbq_pkg::OpQueueTx, 8'hA5);
    queue_request(sbq_pkg::OpClear,   8'h00);  // clear while busy, the shifter stays busy
    queue_request(sbq_pkg::OpQueueTx, 8'h3C);  // so this byte must wait
    queue_request(sbq_pkg::OpDone,    8'hC3);
    queue_request(sbq_pkg::OpDone,    8'h55);
    queue_request(sbq_pkg::OpTakeRx,  8'h00);
    queue_request(sbq_pkg::OpTakeRx,  8'h00);
    queue_request(sbq_pkg::OpTakeRx,  8'h00);

    // Random part, shaped as bursts of one operation so that the rings really fill
    // up and run dry (transmit full, receive overflow), mixed with short runs of
    // arbitrary operations and the odd clear.
    while (requests_to_send.size() < ItemTarget) begin
      burst = $urandom_range(1, 20);
      case ($urandom_range(0, 11))
        0, 1, 2, 3: kind = sbq_pkg::OpQueueTx;
        4, 5, 6, 7: kind = sbq_pkg::OpDone;
        8, 9:       kind = sbq_pkg::OpTakeRx;
        10:         kind = sbq_pkg::OpClear;
        default:    kind = sbq_pkg::op_e'(2'b00);
      endcase
      if (kind == sbq_pkg::OpClear) begin
        queue_request(sbq_pkg::OpClear, 8'($urandom));
      end else if ($urandom_range(0, 11) == 11) begin
        repeat ($urandom_range(1, 8))
          queue_request(sbq_pkg::op_e'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        repeat (burst) queue_request(kind, 8'($urandom));
      end
    end
    total_items = requests_to_send.size();

    // Single reset at the start of the run.
    rst_ni = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A stretch with no idling on either side, then the long hold-off.
    while (items_accepted < 150) @(posedge clk_i);
    steady_flow <= 1'b1;
    while (items_accepted < 250) @(posedge clk_i);
    steady_flow  <= 1'b0;
    holds_wanted <= holds_wanted + 1;

    // Drain: every item accepted, every result seen, then a short tail in which
    // no stray result may appear.
    while (items_accepted < total_items) @(posedge clk_i);
    while (awaited_replies.size() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Ran %0d items: %0d queue, %0d take, %0d done, %0d clear; %0d shifter starts",
             total_items, op_seen[sbq_pkg::OpQueueTx], op_seen[sbq_pkg::OpTakeRx],
             op_seen[sbq_pkg::OpDone], op_seen[sbq_pkg::OpClear], shifter_starts);
    $display("Transmit full %0d, receive empty %0d, dropped bytes %0d, input stalled %0d cycles",
             tx_refusals, rx_empty_answers, rx_drops, input_stall_cycles);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
